// ===== sv/srfd_pkg.sv =====
// shared types, constants and crc step function for the station reply frame decoder
package srfd_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    REG_CRC_POLYNOMIAL = 2'd0,
    REG_WAKEUP_CODE    = 2'd1,
    REG_START_CODE     = 2'd2,
    REG_END_CODE       = 2'd3
  } reg_index_t;

  // configuration reset values
  localparam logic [15:0] PolyReset   = 16'h8005;
  localparam logic [7:0]  WakeupReset = 8'hFF;
  localparam logic [7:0]  StartReset  = 8'h02;
  localparam logic [7:0]  EndReset    = 8'h03;

  // closing status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_END   = 3'd3,
    ST_BAD_CRC   = 3'd4
  } status_t;

  // parser phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_START   = 9'b000000010,
    PH_COMMAND = 9'b000000100,
    PH_LENGTH  = 9'b000001000,
    PH_BODY    = 9'b000010000,
    PH_CRC_HI  = 9'b000100000,
    PH_CRC_LO  = 9'b001000000,
    PH_END     = 9'b010000000,
    PH_DONE    = 9'b100000000
  } phase_t;

  // live configuration
  typedef struct packed {
    logic [15:0] crc_polynomial;
    logic [7:0]  wakeup_code;
    logic [7:0]  start_code;
    logic [7:0]  end_code;
  } cfg_t;

  // one received beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_byte;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic       frame_done;
    logic [7:0] data_value;
    logic [7:0] data_position;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
    logic [2:0] frame_status;
  } res_t;

  // shift one byte msb first through the crc register
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    logic        top;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      top = c[15];
      c = {c[14:0], data[i]};
      if (top) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/srfd_intf.sv =====
// handshake channel interfaces for received bytes, results and configuration writes

interface srfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       first_byte;
  modport source (output valid, output rx_byte, output first_byte, input ready);
  modport sink (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface srfd_res_if;
  logic       valid;
  logic       ready;
  logic       frame_done;
  logic [7:0] data_value;
  logic [7:0] data_position;
  logic [7:0] frame_command;
  logic [7:0] payload_length;
  logic [2:0] frame_status;
  modport source (output valid, output frame_done, output data_value, output data_position,
                  output frame_command, output payload_length, output frame_status,
                  input ready);
  modport sink (input valid, input frame_done, input data_value, input data_position,
                input frame_command, input payload_length, input frame_status,
                output ready);
endinterface

interface srfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/srfd_cfg_regs.sv =====
// configuration register file written over the cfg channel
module srfd_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  srfd_cfg_if.sink            cfg,
  output srfd_pkg::cfg_t      regs
);

  // always ready for a write beat
  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.crc_polynomial <= srfd_pkg::PolyReset;
      regs.wakeup_code    <= srfd_pkg::WakeupReset;
      regs.start_code     <= srfd_pkg::StartReset;
      regs.end_code       <= srfd_pkg::EndReset;
    end else if (cfg.valid) begin
      unique case (srfd_pkg::reg_index_t'(cfg.index))
        srfd_pkg::REG_CRC_POLYNOMIAL: regs.crc_polynomial <= cfg.data;
        srfd_pkg::REG_WAKEUP_CODE:    regs.wakeup_code    <= cfg.data[7:0];
        srfd_pkg::REG_START_CODE:     regs.start_code     <= cfg.data[7:0];
        srfd_pkg::REG_END_CODE:       regs.end_code       <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/srfd_parser.sv =====
// frame parse state machine with running crc, one beat per step
module srfd_parser (
  input  logic                clk,
  input  logic                rst,
  input  srfd_pkg::cfg_t      regs,
  input  logic                step,
  input  srfd_pkg::beat_t     beat,
  output logic                res_valid,
  output srfd_pkg::res_t      res
);

  srfd_pkg::phase_t phase, phase_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  byte_counter, byte_counter_next;
  logic [15:0] crc_register, crc_register_next;
  logic [15:0] received_crc, received_crc_next;
  logic [7:0]  counter_inc;

  assign counter_inc = byte_counter + 8'd1;

  // next state and result for the beat in the input register
  always_comb begin
    phase_next        = phase;
    held_command_next = held_command;
    held_length_next  = held_length;
    byte_counter_next = byte_counter;
    crc_register_next = crc_register;
    received_crc_next = received_crc;
    res_valid         = 1'b0;
    res               = '0;
    if (beat.first_byte) begin
      // restart: a fresh frame begins here
      held_command_next = '0;
      held_length_next  = '0;
      byte_counter_next = '0;
      crc_register_next = '0;
      received_crc_next = '0;
      if (beat.rx_byte == regs.wakeup_code) begin
        phase_next = srfd_pkg::PH_START;
      end else if (beat.rx_byte == regs.start_code) begin
        phase_next = srfd_pkg::PH_COMMAND;
      end else begin
        res_valid        = 1'b1;
        res.frame_done   = 1'b1;
        res.frame_status = srfd_pkg::ST_BAD_START;
        phase_next       = srfd_pkg::PH_DONE;
      end
    end else begin
      unique case (phase) inside
        srfd_pkg::PH_IDLE, srfd_pkg::PH_DONE: ;
        srfd_pkg::PH_START: begin
          if (beat.rx_byte == regs.start_code) begin
            phase_next = srfd_pkg::PH_COMMAND;
          end else begin
            res_valid        = 1'b1;
            res.frame_done   = 1'b1;
            res.frame_status = srfd_pkg::ST_BAD_START;
            phase_next       = srfd_pkg::PH_DONE;
          end
        end
        srfd_pkg::PH_COMMAND: begin
          held_command_next = beat.rx_byte;
          phase_next        = srfd_pkg::PH_LENGTH;
        end
        srfd_pkg::PH_LENGTH: begin
          held_length_next = beat.rx_byte;
          if (beat.rx_byte < 8'd2) begin
            res_valid         = 1'b1;
            res.frame_done    = 1'b1;
            res.frame_command = held_command;
            res.frame_status  = srfd_pkg::ST_BAD_LEN;
            phase_next        = srfd_pkg::PH_DONE;
          end else begin
            crc_register_next = {held_command, beat.rx_byte};
            byte_counter_next = '0;
            phase_next        = srfd_pkg::PH_BODY;
          end
        end
        srfd_pkg::PH_BODY: begin
          crc_register_next = srfd_pkg::crc_byte(crc_register, beat.rx_byte,
                                                 regs.crc_polynomial);
          // the two station bytes are covered by the crc but not passed on
          if (byte_counter >= 8'd2) begin
            res_valid          = 1'b1;
            res.data_value     = beat.rx_byte;
            res.data_position  = byte_counter - 8'd2;
            res.frame_command  = held_command;
            res.payload_length = held_length - 8'd2;
            res.frame_status   = srfd_pkg::ST_OK;
          end
          byte_counter_next = counter_inc;
          if (counter_inc >= held_length) begin
            phase_next = srfd_pkg::PH_CRC_HI;
          end
        end
        srfd_pkg::PH_CRC_HI: begin
          received_crc_next = {beat.rx_byte, 8'h00};
          // even covered count needs 16 padding bits: first 8 go here
          if (!held_length[0]) begin
            crc_register_next = srfd_pkg::crc_byte(crc_register, 8'h00,
                                                   regs.crc_polynomial);
          end
          phase_next = srfd_pkg::PH_CRC_LO;
        end
        srfd_pkg::PH_CRC_LO: begin
          received_crc_next = {received_crc[15:8], beat.rx_byte};
          crc_register_next = srfd_pkg::crc_byte(crc_register, 8'h00,
                                                 regs.crc_polynomial);
          phase_next        = srfd_pkg::PH_END;
        end
        srfd_pkg::PH_END: begin
          res_valid          = 1'b1;
          res.frame_done     = 1'b1;
          res.frame_command  = held_command;
          res.payload_length = held_length - 8'd2;
          if (beat.rx_byte != regs.end_code) begin
            res.frame_status = srfd_pkg::ST_BAD_END;
          end else if (crc_register != received_crc) begin
            res.frame_status = srfd_pkg::ST_BAD_CRC;
          end else begin
            res.frame_status = srfd_pkg::ST_OK;
          end
          phase_next = srfd_pkg::PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= srfd_pkg::PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // frame context registers
  always_ff @(posedge clk) begin
    if (step) begin
      held_command <= held_command_next;
      held_length  <= held_length_next;
      byte_counter <= byte_counter_next;
      crc_register <= crc_register_next;
      received_crc <= received_crc_next;
    end
  end

endmodule

// ===== sv/station_reply_frame_decoder.sv =====
// station reply frame decoder: registered input byte, registered result
// throughput one byte per cycle while the result channel keeps up
// an input register and a result register bound the single parse stage
// a byte that makes no result moves on even while a result waits downstream
// rst (synchronous) empties both registers, returns the parser to idle and
// loads the configuration reset values
module station_reply_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  srfd_rx_if.sink     rx,
  srfd_res_if.source  result,
  srfd_cfg_if.sink    cfg
);

  srfd_pkg::cfg_t  regs;
  srfd_pkg::beat_t beat;
  srfd_pkg::res_t  res;
  srfd_pkg::res_t  res_q;
  logic            beat_valid;
  logic            res_valid;
  logic            out_valid;
  logic            advance;

  srfd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  srfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .step      (advance),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  // the held beat moves on when its result has a place to go or when it makes no result
  assign advance  = beat_valid && (!out_valid || result.ready || !res_valid);
  assign rx.ready = !beat_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      beat_valid <= 1'b1;
    end else if (advance) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      beat.rx_byte    <= rx.rx_byte;
      beat.first_byte <= rx.first_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.frame_done     = res_q.frame_done;
  assign result.data_value     = res_q.data_value;
  assign result.data_position  = res_q.data_position;
  assign result.frame_command  = res_q.frame_command;
  assign result.payload_length = res_q.payload_length;
  assign result.frame_status   = res_q.frame_status;

endmodule

// ===== sv/srfd_checker.sv =====
// port-level checks for the station reply frame decoder, bound to the top level
module srfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       frame_done,
  input logic [7:0] data_value,
  input logic [7:0] data_position,
  input logic [7:0] frame_command,
  input logic [7:0] payload_length,
  input logic [2:0] frame_status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_done) && $stable(data_value)
      && $stable(data_position) && $stable(frame_status))
    else $error("result beat changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a data beat lies inside the data field and carries ok status
  a_data_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |->
      frame_status == srfd_pkg::ST_OK && data_position < payload_length)
    else $error("data beat outside data field");

  // a bad start closes with no command and no length
  a_bad_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done && frame_status == srfd_pkg::ST_BAD_START |->
      frame_command == 8'd0 && payload_length == 8'd0 && data_value == 8'd0)
    else $error("bad start closing beat carries frame fields");

endmodule

bind station_reply_frame_decoder srfd_checker u_srfd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .frame_done     (result.frame_done),
  .data_value     (result.data_value),
  .data_position  (result.data_position),
  .frame_command  (result.frame_command),
  .payload_length (result.payload_length),
  .frame_status   (result.frame_status)
);
